// ===== rtl/nfa_pkg.sv =====
// nfa_pkg: shared types and constants for the nfa regex match engine
// no dependencies
package nfa_pkg;
  localparam int NumStates = 16;
  localparam int AlphaSize = 256;
  localparam int StW = $clog2(NumStates);
  localparam int SymW = $clog2(AlphaSize);

  typedef enum logic [1:0] {
    ACT_LOAD_SYM = 2'd0,
    ACT_LOAD_EPS = 2'd1,
    ACT_BEGIN    = 2'd2,
    ACT_FEED     = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_START  = 1'b0,
    CFG_ACCEPT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GATHER, ST_CLOSE, ST_OUT, ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  state_index;
    logic [7:0]  symbol;
    logic [15:0] target_mask;
  } in_t;

  typedef struct packed {
    logic [15:0] active_set;
    logic        alive;
    logic        matched;
  } out_t;

  // per cell control from the sequencer
  typedef struct packed {
    logic load;  // parallel load of cell set bits
    logic shift; // shift request; nfa_cell does not use it and the sequencer drives it low
    logic eps_en;
  } cell_ctl_t;
endpackage

// ===== rtl/nfa_cell.sv =====
// nfa_cell: one state cell; holds its epsilon row and its active bit
// depends on nfa_pkg
module nfa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          eps_we_i,
  input  logic [nfa_pkg::NumStates-1:0] eps_row_i,
  input  nfa_pkg::cell_ctl_t            ctl_i,
  input  logic                          load_bit_i,
  input  logic [nfa_pkg::NumStates-1:0] or_i,
  output logic [nfa_pkg::NumStates-1:0] or_o,
  output logic                          bit_o
);
  import nfa_pkg::*;
  logic [NumStates-1:0] eps_q;
  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
      bit_q <= 1'b0;
    end else begin
      if (eps_we_i) eps_q <= eps_row_i;
      if (ctl_i.load) bit_q <= load_bit_i;
    end
  end

  // accumulate this cell's epsilon row into the chain
  assign or_o = or_i | ((bit_q && ctl_i.eps_en) ? eps_q : '0);
  assign bit_o = bit_q;
endmodule

// ===== rtl/nfa_regex_match_engine.sv =====
// nfa_regex_match_engine: top level, sequencer, transition memory, cell chain
// depends on nfa_pkg and nfa_cell
//
// usage: host sends transactions on in_*; each gives exactly one result on out_*
// load actions write the transition memory (one column per symbol) or an
// epsilon row in the cell chain and report the active set unchanged
// begin: active set becomes the epsilon closure of start_state
// feed: the transition memory is read one source state per cycle (single read
// port), then closure rounds run until the set stops changing, one round a
// cycle through the chained cells
// after reset a clearing pass writes zero to all 4096 memory words, during which
// in_ready_o is low; cfg writes are taken at any time
// when out_ready_i is low the result waits in the output register and no new
// transaction is taken; one transaction is in flight at a time
module nfa_regex_match_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nfa_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nfa_pkg::out_t     out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [3:0]        cfg_data_i
);
  import nfa_pkg::*;
  localparam int AW = StW + SymW;

  state_e st_q, st_d;
  logic [3:0] start_q, accept_q;
  logic [NumStates-1:0] set_q, set_d, acc_q, acc_d;
  logic [StW-1:0] cnt_q, cnt_d;
  logic [AW:0] clr_q;
  in_t item_q;
  out_t out_q;
  logic out_v_q;

  // transition memory
  logic [NumStates-1:0] mem [AlphaSize*NumStates];
  logic [NumStates-1:0] rd_q;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [NumStates-1:0] mem_wd;

  logic sym_ok, in_acc, set_bit_rd;
  assign sym_ok = (item_q.symbol != '0);
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == ST_IDLE) && !out_v_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {item_q.state_index, item_q.symbol};
    mem_wd = item_q.target_mask;
    if (st_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q[AW-1:0];
      mem_wd = '0;
    end else if (in_acc && in_data_i.action == ACT_LOAD_SYM && in_data_i.symbol != '0) begin
      mem_we = 1'b1;
      mem_wa = {in_data_i.state_index, in_data_i.symbol};
      mem_wd = in_data_i.target_mask;
    end
    // first row of a feed is read on the accepting edge, before item_q is loaded
    mem_ra = {cnt_d, (st_q == ST_IDLE) ? in_data_i.symbol : item_q.symbol};
  end

  // cell chain
  cell_ctl_t ctl;
  logic [NumStates-1:0] chain [NumStates+1];
  logic [NumStates-1:0] bits, next_set;
  assign chain[0] = '0;
  genvar g;
  generate
    for (g = 0; g < NumStates; g++) begin : g_cell
      nfa_cell u_cell (
        .clk_i, .rst_ni,
        .eps_we_i (in_acc && in_data_i.action == ACT_LOAD_EPS
                   && in_data_i.state_index == StW'(g)),
        .eps_row_i(in_data_i.target_mask),
        .ctl_i    (ctl),
        .load_bit_i(set_d[g]),
        .or_i     (chain[g]),
        .or_o     (chain[g+1]),
        .bit_o    (bits[g])
      );
    end
  endgenerate
  assign next_set = bits | chain[NumStates];

  always_comb begin
    ctl = '0;
    ctl.eps_en = 1'b1;
    ctl.load = (set_d != set_q);
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR:  if (clr_q[AW]) st_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.action)
            ACT_BEGIN: st_d = ST_CLOSE;
            ACT_FEED:  st_d = ST_GATHER;
            default:   st_d = ST_OUT;
          endcase
        end
      end
      ST_GATHER: if (cnt_q == StW'(NumStates-1)) st_d = ST_CLOSE;
      ST_CLOSE:  if (next_set == set_q) st_d = ST_OUT;
      ST_OUT:    st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // datapath
  assign set_bit_rd = set_q[cnt_q];
  always_comb begin
    set_d = set_q;
    acc_d = acc_q;
    cnt_d = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.action == ACT_BEGIN) begin
          set_d = NumStates'(1) << start_q;
        end
        acc_d = '0;
      end
      ST_GATHER: begin
        cnt_d = cnt_q + StW'(1);
        // rd_q holds the row of source state cnt_q
        if (set_bit_rd && sym_ok) acc_d = acc_q | rd_q;
        if (cnt_q == StW'(NumStates-1)) set_d = (set_bit_rd && sym_ok) ? (acc_q | rd_q) : acc_q;
      end
      ST_CLOSE: set_d = next_set;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      set_q <= '0;
      acc_q <= '0;
      start_q <= 4'd0;
      accept_q <= 4'd1;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      cnt_q <= cnt_d;
      set_q <= set_d;
      acc_q <= acc_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_START:  start_q <= cfg_data_i;
          CFG_ACCEPT: accept_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == ST_OUT) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (st_q == ST_OUT) begin
      out_q.active_set <= set_q;
      out_q.alive <= (set_q != '0);
      out_q.matched <= set_q[accept_q];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  // the cell bits always mirror the active set register
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni) bits == set_q)
    else $error("cell bits out of step with set");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT) |=> out_valid_o) else $error("result lost");
endmodule
